/* design/clws_pkg.sv */
// Shared types and constants for the byte list with search.
package clws_pkg;

    // Default number of list entries
    localparam int CLWS_DEPTH = 16;

    // Fixed field widths of the request and result beats
    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int MPOS_W = 4;
    localparam int CNTO_W = 5;

    // Byte returned by a read beyond the last item ('?')
    localparam logic [BYTE_W-1:0] UNKNOWN_BYTE = 8'd63;

    // Request commands; the two spare codes leave the list unchanged
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_FRONT = 3'd0,
        CMD_REMOVE_FIRST = 3'd1,
        CMD_REMOVE_LAST  = 3'd2,
        CMD_CLEAR        = 3'd3,
        CMD_READ         = 3'd4,
        CMD_SEARCH       = 3'd5
    } t_cmd;

    // Controller to datapath strobes
    typedef struct packed {
        logic load;       // capture the request beat
        logic exec;       // carry out the captured command
        logic rd_done;    // registered read data is ready for the result
        logic srch_step;  // advance the search walk by one entry
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic read_hit;   // captured read addresses a held item
        logic is_search;  // captured command is a search
        logic srch_done;  // search has matched or run past the last item
    } t_dp_sts;

endpackage

/* design/char_list_with_search.sv */
// Top level of the bounded byte list with front insert, removal, read and search.
//
// Requests arrive on the input channel (i_in_valid / o_in_ready) as one beat
// carrying a command, a byte value and a position. Each request gives exactly
// one result beat on the output channel (o_out_valid / i_out_ready) with the
// read byte, found flag, match position, item count, empty flag and overflow.
// Requests are handled one at a time by a controller and a datapath holding a
// circular store with a single read port and registered read data.
// Insert, remove, clear and spare commands pass from the execute state
// straight to the output state; a read within the list passes through a
// read-wait state first, one out of range goes straight to output.
// A search walks the store one entry a cycle through the read port and
// reaches the output state on a match or once it has run past the last
// item, so a miss on a full list walks every entry.
// The next request is taken in the cycle its predecessor's result is taken.
// While the receiver stalls the result is held and no request is taken.
// Reset empties the list at once; store contents are undefined until written.
module char_list_with_search
    import clws_pkg::*;
#(
    parameter int DEPTH = CLWS_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_value,
    input  logic [BYTE_W-1:0] i_position,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_data,
    output logic              o_found,
    output logic [MPOS_W-1:0] o_match_position,
    output logic [CNTO_W-1:0] o_item_count,
    output logic              o_is_empty,
    output logic              o_overflow
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequence each request
    clws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Hold the list and build the result beat
    clws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_data           (o_data),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_item_count     (o_item_count),
        .o_is_empty       (o_is_empty),
        .o_overflow       (o_overflow)
    );

endmodule

/* design/clws_ctrl.sv */
// Controller state machine for the byte list with search.
module clws_ctrl
    import clws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_RDWAIT = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_accept;

    // Take a new request when idle or as the pending result leaves
    assign o_in_ready  = (r_state == ST_IDLE) || ((r_state == ST_OUT) && i_out_ready);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_OUT);

    // Drive datapath strobes from the state
    always_comb begin
        o_cmd.load      = in_accept;
        o_cmd.exec      = (r_state == ST_EXEC);
        o_cmd.rd_done   = (r_state == ST_RDWAIT);
        o_cmd.srch_step = (r_state == ST_SEARCH);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_sts.read_hit)       n_state = ST_RDWAIT;
                else if (i_sts.is_search) n_state = ST_SEARCH;
                else                      n_state = ST_OUT;
            end
            ST_RDWAIT: begin
                n_state = ST_OUT;
            end
            ST_SEARCH: begin
                if (i_sts.srch_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = in_accept ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/clws_dp.sv */
// Datapath for the byte list with search: circular store, pointers, result register.
module clws_dp
    import clws_pkg::*;
#(
    parameter int DEPTH = CLWS_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_value,
    input  logic [BYTE_W-1:0] i_position,
    output logic [BYTE_W-1:0] o_data,
    output logic              o_found,
    output logic [MPOS_W-1:0] o_match_position,
    output logic [CNTO_W-1:0] o_item_count,
    output logic              o_is_empty,
    output logic              o_overflow
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
    localparam int SUM_W = IDX_W + 1;

    // Item store, left unreset
    logic [BYTE_W-1:0] mem [DEPTH];

    // Captured request
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_value;
    logic [BYTE_W-1:0] r_pos;

    // List state
    logic [PTR_W-1:0]  r_front;
    logic [CNT_W-1:0]  r_count;

    // Search walk
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_pend_idx;
    logic              r_pend;
    logic [BYTE_W-1:0] r_rd_data;

    // Result register
    logic [BYTE_W-1:0] r_data;
    logic              r_found;
    logic [IDX_W-1:0]  r_mpos;
    logic              r_ovf;

    logic              full;
    logic              empty;
    logic              read_hit;
    logic              walk_more;
    logic              match;
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  front_dec;
    logic [PTR_W-1:0]  front_inc;
    logic [IDX_W-1:0]  idx_sel;
    logic [SUM_W-1:0]  addr_sum;
    logic [SUM_W-1:0]  addr_wrap;
    logic [PTR_W-1:0]  raddr;
    logic [IDX_W-1:0]  cnt_ext;

    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign cnt_ext   = IDX_W'(r_count);
    assign read_hit  = (t_cmd'(r_cmd) == CMD_READ) && (IDX_W'(r_pos) < cnt_ext);
    assign walk_more = (r_idx < r_count);
    assign match     = r_pend && (r_rd_data == r_value);

    assign o_sts.read_hit  = read_hit;
    assign o_sts.is_search = (t_cmd'(r_cmd) == CMD_SEARCH);
    assign o_sts.srch_done = match || !walk_more;

    // Step the front pointer round the circular store
    assign front_dec = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == PTR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    // Map a list position to a store address; for every address read the sum stays below twice the depth
    assign idx_sel   = i_cmd.srch_step ? IDX_W'(r_idx) : IDX_W'(r_pos);
    assign addr_sum  = SUM_W'(r_front) + SUM_W'(idx_sel);
    assign addr_wrap = (addr_sum >= SUM_W'(DEPTH)) ? addr_sum - SUM_W'(DEPTH) : addr_sum;
    assign raddr     = addr_wrap[PTR_W-1:0];

    assign we = i_cmd.exec && (t_cmd'(r_cmd) == CMD_INSERT_FRONT) && !full;
    assign re = (i_cmd.exec && read_hit) || (i_cmd.srch_step && walk_more);

    // Write at the new front, read one address a cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[front_dec] <= r_value;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    // Update pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            unique case (t_cmd'(r_cmd))
                CMD_INSERT_FRONT: begin
                    if (!full) begin
                        r_front <= front_dec;
                        r_count <= r_count + 1'b1;
                    end
                end
                CMD_REMOVE_FIRST: begin
                    if (!empty) begin
                        r_front <= front_inc;
                        r_count <= r_count - 1'b1;
                    end
                end
                CMD_REMOVE_LAST: begin
                    if (!empty) r_count <= r_count - 1'b1;
                end
                CMD_CLEAR: begin
                    r_front <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Walk the store for a search, one read issued and one compare a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.exec) begin
            r_pend <= 1'b0;
        end else if (i_cmd.srch_step) begin
            r_pend <= walk_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_idx <= '0;
        end else if (i_cmd.srch_step && walk_more) begin
            r_idx      <= r_idx + 1'b1;
            r_pend_idx <= r_idx;
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data  <= '0;
            r_found <= 1'b0;
            r_mpos  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_found <= 1'b0;
            r_mpos  <= '0;
            r_ovf   <= (t_cmd'(r_cmd) == CMD_INSERT_FRONT) && full;
            r_data  <= ((t_cmd'(r_cmd) == CMD_READ) && !read_hit) ? UNKNOWN_BYTE : '0;
        end else if (i_cmd.rd_done) begin
            r_data  <= r_rd_data;
            r_found <= 1'b1;
        end else if (i_cmd.srch_step && match) begin
            r_found <= 1'b1;
            r_mpos  <= IDX_W'(r_pend_idx);
        end
    end

    assign o_data           = r_data;
    assign o_found          = r_found;
    assign o_match_position = r_mpos[MPOS_W-1:0];
    assign o_item_count     = cnt_ext[CNTO_W-1:0];
    assign o_is_empty       = empty;
    assign o_overflow       = r_ovf;

    // The count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("item count beyond depth");

    // A dropped insert leaves a full list
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flagged on a list that is not full");

    // A non-zero match position comes only with a match
    a_mpos_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mpos != '0) |-> r_found)
        else $error("match position set without found");

    // A read issued from the execute step returns its data in the next cycle
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && read_hit) |=> i_cmd.rd_done)
        else $error("read data not collected after issue");

endmodule

/* tb/sv/list_result_checker.sv */
// Checker for the byte list: mirrors the list, predicts each result beat and compares it.
`timescale 1ns / 100ps

module list_result_checker
    import clws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_value,
    input  logic [BYTE_W-1:0] i_position,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_found,
    input  logic [MPOS_W-1:0] i_match_position,
    input  logic [CNTO_W-1:0] i_item_count,
    input  logic              i_is_empty,
    input  logic              i_overflow,
    output int                o_mismatch_count,
    output int                o_results_owed
);

    // One result beat, field by field
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              found;
        logic [MPOS_W-1:0] match_position;
        logic [CNTO_W-1:0] item_count;
        logic              is_empty;
        logic              overflow;
    } t_list_result;

    // Mirror of the circular store
    logic [BYTE_W-1:0] list_bytes [CLWS_DEPTH];
    int                head_slot;
    int                held_items;

    t_list_result      owed_results [$];
    int                mismatches;
    int                result_index;

    initial begin
        o_mismatch_count = 0;
        o_results_owed   = 0;
        mismatches       = 0;
        result_index     = 0;
        head_slot        = 0;
        held_items       = 0;
    end

    // Print one line per mismatch (first hundred only) and count every one
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 100)
            $display("result %0d: %s is 0x%0h, should be 0x%0h",
                     result_index, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the mirror and work out its result beat
    task automatic predict_list_result(input logic [CMD_W-1:0] cmd,
                                       input logic [BYTE_W-1:0] val,
                                       input logic [BYTE_W-1:0] pos,
                                       output t_list_result res);
        int k;
        res = '0;
        case (cmd)
            CMD_INSERT_FRONT: begin
                if (held_items >= CLWS_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    head_slot = (head_slot + CLWS_DEPTH - 1) % CLWS_DEPTH;
                    list_bytes[head_slot] = val;
                    held_items++;
                end
            end
            CMD_REMOVE_FIRST: begin
                if (held_items > 0) begin
                    head_slot = (head_slot + 1) % CLWS_DEPTH;
                    held_items--;
                end
            end
            CMD_REMOVE_LAST: begin
                if (held_items > 0)
                    held_items--;
            end
            CMD_CLEAR: begin
                held_items = 0;
                head_slot  = 0;
            end
            CMD_READ: begin
                if (int'(pos) < held_items) begin
                    res.data  = list_bytes[(head_slot + int'(pos)) % CLWS_DEPTH];
                    res.found = 1'b1;
                end else begin
                    res.data = UNKNOWN_BYTE;
                end
            end
            CMD_SEARCH: begin
                // stop at the first match from the front
                for (k = 0; k < held_items && !res.found; k++) begin
                    if (list_bytes[(head_slot + k) % CLWS_DEPTH] == val) begin
                        res.found          = 1'b1;
                        res.match_position = MPOS_W'(k);
                    end
                end
            end
            default: begin
            end
        endcase
        res.item_count = CNTO_W'(held_items);
        res.is_empty   = (held_items == 0);
    endtask

    // Compare result beats first, then take in the request beat of this edge
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            head_slot  = 0;
            held_items = 0;
            owed_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_data, i_found, i_match_position, i_item_count,
                        i_is_empty, i_overflow};
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = owed_results.pop_front();
                    if (got.data !== want.data)
                        report_mismatch("data", got.data, want.data);
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.match_position !== want.match_position)
                        report_mismatch("match_position", got.match_position,
                                        want.match_position);
                    if (got.item_count !== want.item_count)
                        report_mismatch("item_count", got.item_count, want.item_count);
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", got.is_empty, want.is_empty);
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", got.overflow, want.overflow);
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_list_result(i_command, i_value, i_position, want);
                owed_results.push_back(want);
            end
        end
        o_mismatch_count <= mismatches;
        o_results_owed   <= owed_results.size();
    end

endmodule

/* tb/sv/tb_char_list_with_search.sv */
// Testbench top for the byte list: drives request beats, paces the receiver, gives the verdict.
`timescale 1ns / 100ps

module tb_char_list_with_search;
    import clws_pkg::*;

    // Spare command codes, which leave the list alone
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 150;

    // Phase flavours for the random part
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BLEND = 2;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_command;
    logic [BYTE_W-1:0] i_value;
    logic [BYTE_W-1:0] i_position;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [BYTE_W-1:0] o_data;
    logic              o_found;
    logic [MPOS_W-1:0] o_match_position;
    logic [CNTO_W-1:0] o_item_count;
    logic              o_is_empty;
    logic              o_overflow;

    logic              idle_on;
    int                mismatch_count;
    int                results_owed;

    logic [BYTE_W-1:0] value_pool [6];
    int                stall_left;

    char_list_with_search DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_data           (o_data),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_item_count     (o_item_count),
        .o_is_empty       (o_is_empty),
        .o_overflow       (o_overflow)
    );

    list_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_position       (i_position),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_data           (o_data),
        .i_found          (o_found),
        .i_match_position (o_match_position),
        .i_item_count     (o_item_count),
        .i_is_empty       (o_is_empty),
        .i_overflow       (o_overflow),
        .o_mismatch_count (mismatch_count),
        .o_results_owed   (results_owed)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall in bursts of random length while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one request beat and hold it until taken; may idle for a random gap first
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [BYTE_W-1:0] val,
                                input logic [BYTE_W-1:0] pos);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Draw one random request, weighted by the phase flavour
    task automatic send_random_request(input int mix);
        int w_ins;
        int w_rem;
        int w_rd;
        int w_srch;
        int r;
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] pos;
        case (mix)
            MIX_FILL:  begin w_ins = 60; w_rem = 5;  w_rd = 15; w_srch = 16; end
            MIX_DRAIN: begin w_ins = 8;  w_rem = 50; w_rd = 20; w_srch = 20; end
            default:   begin w_ins = 30; w_rem = 25; w_rd = 20; w_srch = 20; end
        endcase
        r = $urandom_range(0, 99);
        if (r < w_ins)
            cmd = CMD_INSERT_FRONT;
        else if (r < w_ins + w_rem)
            cmd = $urandom_range(0, 1) ? CMD_REMOVE_FIRST : CMD_REMOVE_LAST;
        else if (r < w_ins + w_rem + w_rd)
            cmd = CMD_READ;
        else if (r < w_ins + w_rem + w_rd + w_srch)
            cmd = CMD_SEARCH;
        else begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_CLEAR;
                1:       cmd = CMD_SPARE_6;
                default: cmd = CMD_SPARE_7;
            endcase
        end
        // mostly bytes from a small pool so that searches hit at any depth
        val = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 5)]
                                          : BYTE_W'($urandom_range(0, 255));
        pos = ($urandom_range(0, 4) != 0) ? BYTE_W'($urandom_range(0, 17))
                                          : BYTE_W'($urandom_range(0, 255));
        send_request(cmd, val, pos);
    endtask

    // Stimulus: reset, directed beats, random phases, then drain and verdict
    initial begin
        int sent;
        int phase_len;
        int mix;
        int k;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = '0;
        i_value     = '0;
        i_position  = '0;
        i_out_ready = 1'b0;
        idle_on     = 1'b1;
        stall_left  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: removes do nothing, read out of range, search misses
        send_request(CMD_REMOVE_FIRST, 8'h00, 8'h00);
        send_request(CMD_REMOVE_LAST,  8'hFF, 8'hFF);
        send_request(CMD_READ,         8'h00, 8'h00);
        send_request(CMD_SEARCH,       8'h00, 8'h00);
        // remove last on a one-item list empties it
        send_request(CMD_INSERT_FRONT, 8'hFF, 8'h00);
        send_request(CMD_REMOVE_LAST,  8'h00, 8'h00);
        // three items, then reads in and out of range
        send_request(CMD_INSERT_FRONT, 8'h00, 8'hFF);
        send_request(CMD_INSERT_FRONT, 8'hFF, 8'h00);
        send_request(CMD_INSERT_FRONT, 8'hA5, 8'h5A);
        send_request(CMD_READ,         8'h00, 8'd0);
        send_request(CMD_READ,         8'hFF, 8'd2);
        send_request(CMD_READ,         8'h00, 8'd3);
        send_request(CMD_READ,         8'h00, 8'd255);
        // searches: hit in the middle, hit at the back, miss
        send_request(CMD_SEARCH,       8'hFF, 8'h00);
        send_request(CMD_SEARCH,       8'h00, 8'hFF);
        send_request(CMD_SEARCH,       8'h5A, 8'h00);
        send_request(CMD_REMOVE_FIRST, 8'h00, 8'h00);
        send_request(CMD_REMOVE_LAST,  8'h00, 8'h00);
        // spare codes leave the list alone
        send_request(CMD_SPARE_6,      8'hFF, 8'hFF);
        send_request(CMD_SPARE_7,      8'h00, 8'h00);
        // clear returns the front to slot zero
        send_request(CMD_CLEAR,        8'hFF, 8'hFF);
        send_request(CMD_READ,         8'h00, 8'd0);
        send_request(CMD_INSERT_FRONT, 8'h5A, 8'h00);
        send_request(CMD_SEARCH,       8'h5A, 8'h00);
        send_request(CMD_CLEAR,        8'h00, 8'h00);

        // random phases of varying flavour, some with no idling at all
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(30, 80);
            mix       = $urandom_range(MIX_FILL, MIX_BLEND);
            for (k = 0; k < 6; k++)
                value_pool[k] = BYTE_W'($urandom_range(0, 255));
            idle_on <= (RANDOM_ITEMS - sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                if (RANDOM_ITEMS - sent == QUIET_TAIL)
                    idle_on <= 1'b0;
                send_random_request(mix);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        // let the checker count the last request beat, then drain every owed result
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (CLWS_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
